// ===== hdl/bsa_pkg.sv =====
// Shared constants, request codes and control structs for the slot allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bsa_pkg;

   localparam int SLOT_COUNT  = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int SLOT_IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Fixed field widths of the transaction payload
   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 6;
   localparam int DATA_W   = 32;
   localparam int TDATA_W  = ((INDEX_W + DATA_W + 7) / 8) * 8;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_GET   = 2'd2,
      ACT_SET   = 2'd3
   } action_type;

   typedef struct packed {
      logic                   wr_en;
      logic                   rd_en;
      logic [SLOT_IDX_W-1:0]  addr;
      logic [VALUE_WIDTH-1:0] wr_data;
   } store_req_type;

   typedef struct packed {
      logic                  alloc;
      logic                  release_slot;
      logic [SLOT_IDX_W-1:0] addr;
   } map_ctl_type;

   typedef struct packed {
      logic                  any_free;
      logic [SLOT_IDX_W-1:0] grant;
   } map_stat_type;

endpackage

// ===== hdl/bsa_store.sv =====
// Slot value store: synchronous memory with registered read.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_store (
   input  logic                            clock,
   input  logic                            reset,
   input  bsa_pkg::store_req_type          req,
   output logic [bsa_pkg::VALUE_WIDTH-1:0] rd_data
);
   import bsa_pkg::*;

   logic [VALUE_WIDTH-1:0] mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]  valid_ff;
   logic [SLOT_COUNT-1:0]  valid_in;
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic                   rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req.wr_en) begin
         valid_in[req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff  <= mem[req.addr];
         rd_valid_ff <= valid_ff[req.addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ===== hdl/bsa_free_map.sv =====
// Free map register and lowest-free-slot encoder.
// Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_free_map (
   input  logic                  clock,
   input  logic                  reset,
   input  bsa_pkg::map_ctl_type  ctl,
   output bsa_pkg::map_stat_type stat
);
   import bsa_pkg::*;

   logic [SLOT_COUNT-1:0] map_ff;
   logic [SLOT_COUNT-1:0] map_in;
   logic [SLOT_COUNT-1:0] lowest;
   logic [SLOT_IDX_W-1:0] grant;

   // isolate lowest set bit, then OR-encode the one-hot position
   always_comb begin
      lowest = map_ff & (~map_ff + 1'b1);
      grant  = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (lowest[i]) begin
            grant = grant | SLOT_IDX_W'(i);
         end
      end
   end

   assign stat.any_free = |map_ff;
   assign stat.grant    = grant;

   always_comb begin
      map_in = map_ff;
      if (ctl.alloc) begin
         map_in = map_ff & ~lowest;
      end else if (ctl.release_slot) begin
         map_in[ctl.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= '1;
      end else begin
         map_ff <= map_in;
      end
   end

endmodule

// ===== hdl/bitmap_slot_allocator_store.sv =====
// Top level of the lowest-free-first slot allocator with value store.
// Depends on bsa_pkg, bsa_free_map and bsa_store.
//
// One request per cycle is accepted while the result path is not stalled; each
// request gives one response: the value memory has a registered read, followed
// by the response register. Alloc and free update the free map, and free and set
// update the memory, in the cycle of acceptance, so a later request always sees
// their effect. Every slot is free and reads as zero right out of reset
// (per-slot valid bits, no clearing pass).
`timescale 1ns / 1ps

module bitmap_slot_allocator_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [bsa_pkg::TDATA_W-1:0]  req_tdata,  // slot_index, write_value, pad
   input  logic [bsa_pkg::ACTION_W-1:0] req_tuser,  // action
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [bsa_pkg::TDATA_W-1:0]  rsp_tdata,  // granted_index, read_value, pad
   output logic                         rsp_tuser   // ok
);
   import bsa_pkg::*;

   action_type             req_action;
   logic [INDEX_W-1:0]     req_slot;
   logic [DATA_W-1:0]      req_value;
   logic                   req_accept;
   logic                   in_range;
   logic                   out_adv;

   store_req_type          store_req;
   logic [VALUE_WIDTH-1:0] store_rd;
   map_ctl_type            map_ctl;
   map_stat_type           map_stat;

   // stage 1: request accepted, memory read in flight
   logic                   s1_valid_ff, s1_valid_in;
   action_type             s1_action_ff;
   logic                   s1_ok_ff;
   logic [INDEX_W-1:0]     s1_grant_ff;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff;
   logic [INDEX_W-1:0]     rsp_grant_ff;
   logic [DATA_W-1:0]      rsp_value_ff;

   assign req_action = action_type'(req_tuser);
   assign req_slot   = req_tdata[INDEX_W-1:0];
   assign req_value  = req_tdata[INDEX_W+DATA_W-1:INDEX_W];

   assign out_adv    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || out_adv;
   assign req_accept = req_tvalid && req_tready;
   assign in_range   = int'(req_slot) < SLOT_COUNT;

   always_comb begin
      store_req.addr    = SLOT_IDX_W'(req_slot);
      store_req.wr_data = (req_action == ACT_SET) ? VALUE_WIDTH'(req_value) : '0;
      store_req.wr_en   = req_accept && in_range &&
                          (req_action == ACT_SET || req_action == ACT_FREE);
      store_req.rd_en   = req_accept && in_range && (req_action == ACT_GET);

      map_ctl.addr         = SLOT_IDX_W'(req_slot);
      map_ctl.alloc        = req_accept && (req_action == ACT_ALLOC) && map_stat.any_free;
      map_ctl.release_slot = req_accept && in_range && (req_action == ACT_FREE);
   end

   bsa_store u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (store_req),
      .rd_data (store_rd)
   );

   bsa_free_map u_free_map (
      .clock (clock),
      .reset (reset),
      .ctl   (map_ctl),
      .stat  (map_stat)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (out_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_adv) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_action_ff <= req_action;
         if (req_action == ACT_ALLOC) begin
            s1_ok_ff    <= map_stat.any_free;
            s1_grant_ff <= map_stat.any_free ? INDEX_W'(map_stat.grant) : '0;
         end else begin
            s1_ok_ff    <= in_range;
            s1_grant_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && out_adv) begin
         rsp_ok_ff    <= s1_ok_ff;
         rsp_grant_ff <= s1_grant_ff;
         rsp_value_ff <= (s1_ok_ff && s1_action_ff == ACT_GET) ? DATA_W'(store_rd) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {{(TDATA_W-INDEX_W-DATA_W){1'b0}}, rsp_value_ff, rsp_grant_ff};

`ifndef SYNTHESIS
   a_accept_to_s1 : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted transaction did not reach stage 1");

   a_s1_to_rsp : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_adv) |=> rsp_valid_ff)
      else $error("stage 1 advanced without loading response");

   a_grant_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_grant_ff != '0) |-> rsp_ok_ff)
      else $error("nonzero granted index on failed response");
`endif

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for bitmap_slot_allocator_store: lowest-free-first grants,
// free/get/set on the value store, full-map refusals, backpressure on both channels.
// Depends on bsa_pkg and the bitmap_slot_allocator_store RTL.
`timescale 1ns / 1ps

module tb;
   import bsa_pkg::*;

   localparam int RANDOM_ITEMS = 700;
   localparam int TAIL_ITEMS   = 80;    // last stretch of the run has no idling
   localparam int HOLD_AT      = 150;   // replies checked before the long receiver hold
   localparam int HOLD_CYCLES  = 60;
   localparam int WATCHDOG     = 1000;  // cycles with no transaction on either side
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      action_type  act;
      logic [5:0]  idx;
      logic [31:0] wval;
   } slot_request_type;

   typedef struct {
      logic        ok;
      logic [5:0]  granted;
      logic [31:0] rdata;
   } slot_reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [TDATA_W-1:0]  req_tdata = '0;   // slot_index, write_value, pad
   logic [ACTION_W-1:0] req_tuser = ACT_ALLOC;  // action
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [TDATA_W-1:0]  rsp_tdata;   // granted_index, read_value, pad
   logic                rsp_tuser;   // ok

   slot_request_type pending_requests[$];
   slot_reply_type   awaited_replies[$];
   slot_request_type offered;

   // shadow state of the allocator
   logic        slot_free[SLOT_COUNT];
   logic [31:0] slot_value[SLOT_COUNT];

   int   mismatches = 0;
   int   replies_checked = 0;
   int   grants = 0;
   int   refusals = 0;
   int   send_gap = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   bit   hold_used = 1'b0;
   bit   in_tail = 1'b0;
   int   quiet_cycles = 0;

   bitmap_slot_allocator_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   task automatic log_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic queue_request(action_type act, logic [5:0] idx, logic [31:0] wval);
      slot_request_type rq;
      rq.act  = act;
      rq.idx  = idx;
      rq.wval = wval;
      pending_requests.push_back(rq);
   endtask

   // Applies one request to the shadow state and returns the reply it must produce.
   function automatic slot_reply_type allocator_outcome(slot_request_type rq);
      slot_reply_type rp;
      bit             found;
      int             s;
      rp.ok      = 1'b0;
      rp.granted = '0;
      rp.rdata   = '0;
      found      = 1'b0;
      if (rq.act == ACT_ALLOC) begin
         for (s = 0; s < SLOT_COUNT; s++) begin
            if (!found && slot_free[s]) begin
               found      = 1'b1;
               rp.granted = s[5:0];
            end
         end
         if (found) begin
            slot_free[rp.granted] = 1'b0;
            rp.ok = 1'b1;
            grants++;
         end else begin
            refusals++;
         end
      end else if (int'(rq.idx) < SLOT_COUNT) begin
         rp.ok = 1'b1;
         case (rq.act)
            ACT_FREE: begin
               slot_free[rq.idx]  = 1'b1;
               slot_value[rq.idx] = '0;
            end
            ACT_GET: rp.rdata = slot_value[rq.idx];
            default: slot_value[rq.idx] = rq.wval;
         endcase
      end
      return rp;
   endfunction

   // Request driver
   always @(posedge clock) begin
      slot_reply_type rp;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
         in_tail    <= 1'b0;
      end else begin
         in_tail <= (pending_requests.size() < TAIL_ITEMS);
         if (req_tvalid && req_tready) begin
            rp = allocator_outcome(offered);
            awaited_replies.push_back(rp);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap   <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_requests.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (!in_tail && $urandom_range(0, 9) == 0) begin
               send_gap   <= int'($urandom_range(0, 5));
               req_tvalid <= 1'b0;
            end else begin
               offered = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= offered.act;
               req_tdata  <= {2'b00, offered.wval, offered.idx};
            end
         end
      end
   end

   // Reply monitor and receiver backpressure
   always @(posedge clock) begin
      slot_reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_replies.size() == 0) begin
               log_mismatch("unexpected reply, tdata", rsp_tdata[31:0], 32'h0);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_tuser !== want.ok)
                  log_mismatch("ok", 32'(rsp_tuser), 32'(want.ok));
               if (rsp_tdata[5:0] !== want.granted)
                  log_mismatch("granted_index", 32'(rsp_tdata[5:0]), 32'(want.granted));
               if (rsp_tdata[37:6] !== want.rdata)
                  log_mismatch("read_value", rsp_tdata[37:6], want.rdata);
               replies_checked++;
            end
         end
         if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_used && replies_checked >= HOLD_AT) begin
            // long hold so the block backs up and drops req_tready
            hold_used  <= 1'b1;
            hold_left  <= HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!in_tail && $urandom_range(0, 7) == 0) begin
            stall_left <= int'($urandom_range(0, 5));
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      int total;
      int kind;
      int len;
      int k;
      int first_episode;
      logic [5:0] s;

      for (k = 0; k < SLOT_COUNT; k++) begin
         slot_free[k]  = 1'b1;
         slot_value[k] = '0;
      end

      // directed: reset contents, field extremes, unallocated free, value kept on alloc
      queue_request(ACT_GET,   6'd0,  32'h0);
      queue_request(ACT_GET,   6'd63, 32'hFFFF_FFFF);
      queue_request(ACT_SET,   6'd63, 32'hFFFF_FFFF);
      queue_request(ACT_GET,   6'd63, 32'h0);
      queue_request(ACT_SET,   6'd0,  32'h0);
      queue_request(ACT_ALLOC, 6'd63, 32'hFFFF_FFFF);
      queue_request(ACT_ALLOC, 6'd0,  32'h0);
      queue_request(ACT_FREE,  6'd5,  32'h0);
      queue_request(ACT_SET,   6'd2,  32'hA5A5_5A5A);
      queue_request(ACT_ALLOC, 6'd0,  32'h0);
      queue_request(ACT_GET,   6'd2,  32'h0);
      queue_request(ACT_FREE,  6'd2,  32'h0);
      queue_request(ACT_GET,   6'd2,  32'h0);
      queue_request(ACT_FREE,  6'd0,  32'h0);
      queue_request(ACT_ALLOC, 6'd0,  32'h0);
      queue_request(ACT_SET,   6'd42, 32'h5A5A_A5A5);
      queue_request(ACT_GET,   6'd42, 32'h0);
      queue_request(ACT_SET,   6'd63, 32'h0);
      queue_request(ACT_GET,   6'd63, 32'h0);

      // random episodes; the first one is an alloc burst that may run the map dry
      total = pending_requests.size() + RANDOM_ITEMS;
      first_episode = 1;
      while (pending_requests.size() < total) begin
         kind = first_episode ? 0 : int'($urandom_range(0, 3));
         first_episode = 0;
         case (kind)
            0: begin
               len = int'($urandom_range(40, 80));
               for (k = 0; k < len; k++)
                  queue_request(ACT_ALLOC, 6'($urandom_range(0, 63)), $urandom);
            end
            1: begin
               len = int'($urandom_range(10, 40));
               for (k = 0; k < len; k++)
                  queue_request(ACT_FREE, 6'($urandom_range(0, 63)), $urandom);
            end
            2: begin
               len = int'($urandom_range(10, 40));
               for (k = 0; k < len; k++)
                  queue_request(action_type'($urandom_range(0, 3)),
                                6'($urandom_range(0, 63)), $urandom);
            end
            default: begin
               len = int'($urandom_range(5, 20));
               for (k = 0; k < len; k++) begin
                  s = 6'($urandom_range(0, 63));
                  queue_request(ACT_SET, s, $urandom);
                  if ($urandom_range(0, 3) == 0)
                     queue_request(ACT_ALLOC, s, $urandom);
                  queue_request(ACT_GET, s, $urandom);
               end
            end
         endcase
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_tvalid)
         @(posedge clock);
      while (awaited_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (awaited_replies.size() != 0)
         log_mismatch("replies never returned", 32'(awaited_replies.size()), 32'h0);

      $display("Checked %0d replies: %0d slots granted, %0d allocs refused on a full map",
               replies_checked, grants, refusals);
      $display("Covered free/get/set traffic, random stalls and one long receiver hold");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
